@@ rtl/prqs_pkg.sv @@
// Package for the priority ready queue scheduler.
// Holds the command codes, entry and control types, and fixed field widths.
// Used by prqs_cell and priority_ready_queue_scheduler_unit.
package prqs_pkg;

  localparam int ID_W        = 8;
  localparam int PRIO_W      = 6;
  localparam int SLICE_W     = 8;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_SET_PRIO = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_TIME_SLICE = 1'b0,
    REG_MLFQS_MODE = 1'b1
  } reg_idx_t;

  localparam logic [SLICE_W-1:0] TIME_SLICE_RST = 8'd4;
  localparam logic [SLICE_W-1:0] TICK_MAX       = 8'hFF;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell of the row in the cycle a transaction is taken.
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

@@ rtl/prqs_cell.sv @@
// One slot of the shift-register priority queue.
// Depends on prqs_pkg for the entry and control types.
module prqs_cell (
  input  logic                  clk,
  input  prqs_pkg::cell_ctrl_t  ctrl,
  input  logic                  occupied,
  input  prqs_pkg::entry_t      prev_entry,
  input  logic                  prev_keep,
  input  prqs_pkg::entry_t      next_entry,
  output prqs_pkg::entry_t      entry,
  output logic                  keep
);

  prqs_pkg::entry_t entry_r;
  prqs_pkg::entry_t entry_nxt;

  // A slot keeps its entry on insert when it outranks or ties the newcomer,
  // which leaves equal priorities in arrival order.
  assign keep  = occupied && (entry_r.prio >= ctrl.new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.insert && !keep) begin
      entry_nxt = prev_keep ? ctrl.new_entry : prev_entry;
    end else if (ctrl.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/priority_ready_queue_scheduler_unit.sv @@
// Top level of the priority ready queue scheduler.
// Depends on prqs_pkg and instantiates a row of prqs_cell slots.
//
// The block takes one command transaction per clock cycle while the result side
// does not stall it, and returns one result transaction for each, in order, in the
// cycle after it is taken. The ready queue is a row of QUEUE_DEPTH slots kept sorted
// by priority: every slot decides locally whether to hold, load the new thread or
// take its neighbor's entry, so an enqueue or a dispatch updates every slot at the
// same clock edge whatever the fill level. A result register decouples the two
// channels; a new command is taken whenever that register is empty or being drained.
// Registers are to be written through the configuration port only while idle; the block does not enforce this.
module priority_ready_queue_scheduler_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Bits 7:0 thread_id, bits 13:8 priority_req, bits 15:14 zero.
  input  logic [prqs_pkg::IN_DATA_W-1:0]      in_tdata,
  // Bits 1:0 command.
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Bits 7:0 next_id, 8 next_valid, 9 preempt, 10 dropped,
  // bits 17:11 queue_count, bits 23:18 zero.
  output logic [prqs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [prqs_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [prqs_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [prqs_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers.
  logic [prqs_pkg::SLICE_W-1:0] time_slice_r;
  logic                         mlfqs_mode_r;
  prqs_pkg::reg_idx_t           cfg_idx;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = prqs_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      prqs_pkg::REG_TIME_SLICE:
        cfg_prdata = {{(prqs_pkg::CFG_DATA_W-prqs_pkg::SLICE_W){1'b0}}, time_slice_r};
      prqs_pkg::REG_MLFQS_MODE:
        cfg_prdata = {{(prqs_pkg::CFG_DATA_W-1){1'b0}}, mlfqs_mode_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_slice_r <= prqs_pkg::TIME_SLICE_RST;
      mlfqs_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_idx == prqs_pkg::REG_TIME_SLICE) begin
        time_slice_r <= cfg_pwdata[prqs_pkg::SLICE_W-1:0];
      end else begin
        mlfqs_mode_r <= cfg_pwdata[0];
      end
    end
  end

  // Scheduler state.
  logic [CW-1:0]                count_r, count_nxt;
  logic [prqs_pkg::PRIO_W-1:0]  run_prio_r, run_prio_nxt;
  logic [prqs_pkg::SLICE_W-1:0] ticks_r, ticks_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [prqs_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  prqs_pkg::cmd_t               cmd;
  logic [prqs_pkg::ID_W-1:0]    in_id;
  logic [prqs_pkg::PRIO_W-1:0]  in_prio;
  logic                         fire;
  logic                         full;
  logic                         empty;
  prqs_pkg::cell_ctrl_t         ctrl;

  prqs_pkg::entry_t             entries [QUEUE_DEPTH];
  logic                         keeps   [QUEUE_DEPTH];

  assign cmd     = prqs_pkg::cmd_t'(in_tuser);
  assign in_id   = in_tdata[prqs_pkg::ID_W-1:0];
  assign in_prio = in_tdata[prqs_pkg::ID_W +: prqs_pkg::PRIO_W];

  assign in_tready = !out_tvalid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  assign ctrl.insert         = fire && (cmd == prqs_pkg::CMD_ENQUEUE) && !full;
  assign ctrl.pop            = fire && (cmd == prqs_pkg::CMD_DISPATCH) && !empty;
  assign ctrl.new_entry.id   = in_id;
  assign ctrl.new_entry.prio = in_prio;

  // Row of slots; slot 0 is the front of the queue.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    prqs_pkg::entry_t prev_e;
    prqs_pkg::entry_t next_e;
    logic             prev_k;

    if (i == 0) begin : g_first
      assign prev_e = ctrl.new_entry;
      assign prev_k = 1'b1;
    end else begin : g_rest
      assign prev_e = entries[i-1];
      assign prev_k = keeps[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = entries[i];
    end else begin : g_inner
      assign next_e = entries[i+1];
    end

    prqs_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < count_r),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .entry      (entries[i]),
      .keep       (keeps[i])
    );
  end

  always_comb begin
    logic [prqs_pkg::ID_W-1:0] next_id;
    logic                      next_valid;
    logic                      preempt;
    logic                      dropped;

    next_id      = '0;
    next_valid   = 1'b0;
    preempt      = 1'b0;
    dropped      = 1'b0;
    count_nxt    = count_r;
    run_prio_nxt = run_prio_r;
    ticks_nxt    = ticks_r;

    unique case (cmd)
      prqs_pkg::CMD_ENQUEUE: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
          preempt   = (in_prio > run_prio_r);
        end
      end
      prqs_pkg::CMD_DISPATCH: begin
        if (!empty) begin
          next_id      = entries[0].id;
          next_valid   = 1'b1;
          run_prio_nxt = entries[0].prio;
          count_nxt    = count_r - 1'b1;
        end else begin
          run_prio_nxt = '0;
        end
        ticks_nxt = '0;
      end
      prqs_pkg::CMD_TICK: begin
        if (ticks_r != prqs_pkg::TICK_MAX) begin
          ticks_nxt = ticks_r + 1'b1;
        end
        preempt = (ticks_nxt >= time_slice_r);
      end
      prqs_pkg::CMD_SET_PRIO: begin
        if (!mlfqs_mode_r) begin
          run_prio_nxt = in_prio;
          preempt      = !empty && (entries[0].prio > in_prio);
        end
      end
      default: begin
      end
    endcase

    out_tdata_nxt = {{(prqs_pkg::OUT_DATA_W-prqs_pkg::COUNT_OUT_W-prqs_pkg::ID_W-3){1'b0}},
                     prqs_pkg::COUNT_OUT_W'(count_nxt), dropped, preempt, next_valid, next_id};

    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (fire) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      run_prio_r   <= '0;
      ticks_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (fire) begin
        count_r    <= count_nxt;
        run_prio_r <= run_prio_nxt;
        ticks_r    <= ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ verif/prqs_sched_checker.sv @@
// Checker for the priority ready queue scheduler: watches the command, result and register
// ports, keeps its own copy of the ready queue and compares every result transaction.
// Depends on prqs_pkg for widths, command codes and register indexes.
module prqs_sched_checker
  import prqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending_results,
  output int                    results_checked,
  output int                    drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Result transaction layout, lowest bits last in the declaration.
  typedef struct packed {
    logic [5:0]             pad;
    logic [COUNT_OUT_W-1:0] count;
    logic                   dropped;
    logic                   preempt;
    logic                   valid;
    logic [ID_W-1:0]        id;
  } sched_result_t;

  logic [ID_W-1:0]    ready_ids[$];
  logic [PRIO_W-1:0]  ready_prios[$];
  logic [PRIO_W-1:0]  running_prio;
  logic [SLICE_W-1:0] ticks_used;
  logic [SLICE_W-1:0] slice_len;
  logic               mlfqs_on;

  sched_result_t      expected_q[$];
  sched_result_t      want;
  sched_result_t      got;
  logic [31:0]        want_rd;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    results_checked = 0;
    drops_seen      = 0;
  end

  function automatic sched_result_t schedule(cmd_t cmd, logic [ID_W-1:0] id,
                                             logic [PRIO_W-1:0] prio);
    sched_result_t r;
    int pos;
    r = '0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (ready_ids.size() >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          // Equal priorities stay in arrival order, so skip past them.
          pos = 0;
          while (pos < ready_ids.size() && ready_prios[pos] >= prio) pos++;
          ready_ids.insert(pos, id);
          ready_prios.insert(pos, prio);
          r.preempt = (prio > running_prio);
        end
      end
      CMD_DISPATCH: begin
        if (ready_ids.size() > 0) begin
          r.id         = ready_ids.pop_front();
          r.valid      = 1'b1;
          running_prio = ready_prios.pop_front();
        end else begin
          running_prio = '0;
        end
        ticks_used = '0;
      end
      CMD_TICK: begin
        if (ticks_used != TICK_MAX) ticks_used++;
        r.preempt = (ticks_used >= slice_len);
      end
      CMD_SET_PRIO: begin
        if (!mlfqs_on) begin
          running_prio = prio;
          r.preempt = (ready_prios.size() > 0) && (ready_prios[0] > prio);
        end
      end
    endcase
    r.count = COUNT_OUT_W'(ready_ids.size());
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_ids.delete();
      ready_prios.delete();
      expected_q.delete();
      running_prio = '0;
      ticks_used   = '0;
      slice_len    = TIME_SLICE_RST;
      mlfqs_on     = 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (reg_idx_t'(cfg_paddr[2]))
            REG_TIME_SLICE: slice_len = cfg_pwdata[SLICE_W-1:0];
            REG_MLFQS_MODE: mlfqs_on  = cfg_pwdata[0];
          endcase
        end else begin
          case (reg_idx_t'(cfg_paddr[2]))
            REG_TIME_SLICE: want_rd = {24'd0, slice_len};
            REG_MLFQS_MODE: want_rd = {31'd0, mlfqs_on};
          endcase
          compare_field("register read", want_rd, cfg_prdata);
        end
      end
      if (in_tvalid && in_tready) begin
        want = schedule(cmd_t'(in_tuser), in_tdata[ID_W-1:0], in_tdata[ID_W+:PRIO_W]);
        if (want.dropped) drops_seen++;
        expected_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = sched_result_t'(out_tdata);
        if (expected_q.size() == 0) begin
          $display("%0t ns: result transaction 0x%0h arrived with nothing expected",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("next_id", want.id, got.id);
          compare_field("next_valid", want.valid, got.valid);
          compare_field("preempt", want.preempt, got.preempt);
          compare_field("dropped", want.dropped, got.dropped);
          compare_field("queue_count", want.count, got.count);
          compare_field("padding", want.pad, got.pad);
          results_checked++;
        end
      end
    end
    pending_results = expected_q.size();
  end

endmodule

@@ verif/priority_ready_queue_scheduler_unit_test.sv @@
// Top of the scheduler testbench: clock, reset, command stimulus, register setup and verdict.
// Depends on prqs_pkg, priority_ready_queue_scheduler_unit and prqs_sched_checker.
module priority_ready_queue_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prqs_pkg::*;

  localparam int QUEUE_DEPTH   = 64;
  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 500;

  typedef enum {
    TRAFFIC_BALANCED,
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_FLOOD,
    TRAFFIC_TICKS
  } traffic_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // Bits 7:0 thread_id, bits 13:8 priority_req, bits 15:14 zero.
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  // Bits 1:0 command.
  logic [1:0]            in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // Bits 7:0 next_id, 8 next_valid, 9 preempt, 10 dropped, bits 17:11 queue_count.
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int  fail_count;
  int  pending_results;
  int  results_checked;
  int  drops_seen;
  int  commands_sent = 0;
  int  settings_used = 0;
  int  idle_cycles   = 0;
  bit  quiet         = 1'b0;

  priority_ready_queue_scheduler_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  prqs_sched_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .drops_seen     (drops_seen)
  );

  initial begin
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles, giving up", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side backpressure: random stall bursts, none in the quiet stretch.
  initial begin
    @(negedge clk);
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic issue(cmd_t cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, prio, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    commands_sent++;
  endtask

  task automatic random_item(traffic_t mood);
    int                roll;
    int                enq_share;
    int                disp_share;
    cmd_t              cmd;
    logic [PRIO_W-1:0] prio;
    roll = $urandom_range(0, 99);
    case (mood)
      TRAFFIC_FILL:  begin enq_share = 75;  disp_share = 10; end
      TRAFFIC_DRAIN: begin enq_share = 10;  disp_share = 65; end
      TRAFFIC_FLOOD: begin enq_share = 100; disp_share = 0;  end
      TRAFFIC_TICKS: begin enq_share = 0;   disp_share = 0;  end
      default:       begin enq_share = 35;  disp_share = 30; end
    endcase
    if (roll < enq_share) cmd = CMD_ENQUEUE;
    else if (roll < enq_share + disp_share) cmd = CMD_DISPATCH;
    else if (mood == TRAFFIC_TICKS || roll % 2 == 0) cmd = CMD_TICK;
    else cmd = CMD_SET_PRIO;
    // Priorities near the ends are favored so that ties and boundary compares are common.
    if ($urandom_range(0, 2) == 0)
      prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 1))
                                  : PRIO_W'($urandom_range(62, 63));
    else
      prio = PRIO_W'($urandom_range(0, 63));
    issue(cmd, ID_W'($urandom_range(0, 255)), prio);
  endtask

  task automatic run_mix(int n, traffic_t mood);
    repeat (n) random_item(mood);
  endtask

  task automatic run_random(int n);
    traffic_t mood;
    mood = TRAFFIC_BALANCED;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) mood = traffic_t'($urandom_range(0, 2));
      random_item(mood);
    end
  endtask

  // Stops commands and waits until every result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_access(bit wr, reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(logic [SLICE_W-1:0] slice, logic mlfqs);
    settle();
    cfg_access(1'b1, REG_TIME_SLICE, {24'd0, slice});
    cfg_access(1'b0, REG_TIME_SLICE, '0);
    cfg_access(1'b1, REG_MLFQS_MODE, {31'd0, mlfqs});
    cfg_access(1'b0, REG_MLFQS_MODE, '0);
    settings_used++;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // Reset settings: slice of four ticks, set-priority honored.
    issue(CMD_DISPATCH, 8'h00, 6'd0);
    issue(CMD_SET_PRIO, 8'hFF, 6'd63);
    issue(CMD_SET_PRIO, 8'h00, 6'd0);
    repeat (5) issue(CMD_TICK, 8'h00, 6'd0);
    issue(CMD_ENQUEUE, 8'hFF, 6'd63);
    issue(CMD_ENQUEUE, 8'h00, 6'd0);
    issue(CMD_ENQUEUE, 8'hAA, 6'd63);
    issue(CMD_ENQUEUE, 8'h55, 6'd21);
    issue(CMD_SET_PRIO, 8'h00, 6'd63);
    issue(CMD_SET_PRIO, 8'h00, 6'd42);
    repeat (5) issue(CMD_DISPATCH, 8'h00, 6'd0);
    issue(CMD_TICK, 8'h00, 6'd0);

    // Shortest slice; fill past capacity, then a dispatch-heavy drain.
    program_regs(8'd1, 1'b0);
    run_random(60);
    run_mix(72, TRAFFIC_FLOOD);
    run_mix(70, TRAFFIC_DRAIN);

    // Longest slice with set-priority ignored; ticks run into saturation.
    program_regs(8'd255, 1'b1);
    run_mix(260, TRAFFIC_TICKS);
    run_random(40);

    program_regs(SLICE_W'($urandom_range(2, 254)), 1'b0);
    run_random(80);

    program_regs(8'd2, 1'b1);
    run_mix(72, TRAFFIC_FLOOD);
    run_random(40);

    // Back to reset settings and full rate on both sides.
    program_regs(TIME_SLICE_RST, 1'b0);
    quiet = 1'b1;
    run_random(60);

    settle();
    $display("Covered %0d commands under %0d register settings, including full-queue drops,",
             commands_sent, settings_used);
    $display("idle dispatches and tick saturation: %0d results checked, %0d enqueues dropped.",
             results_checked, drops_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ priority_ready_queue_scheduler_unit.f @@
rtl/prqs_pkg.sv
rtl/prqs_cell.sv
rtl/priority_ready_queue_scheduler_unit.sv
verif/prqs_sched_checker.sv
verif/priority_ready_queue_scheduler_unit_test.sv
